// ----- rtl/scfd_pkg.sv -----
`timescale 1ns / 1ps

package scfd_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
  localparam int PTR_W         = $clog2(FRAME_BYTES);
  localparam int FILL_W        = $clog2(FRAME_BYTES + 1);
  localparam int CNT_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int OUT_DATA_W    = 40;

  localparam logic CFG_SYNC_BYTE   = 1'b0;
  localparam logic CFG_LENGTH_CODE = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_ERROR   = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;

  // circular index: a + off, off below FRAME_BYTES
  function automatic ptr_t ptr_add(input ptr_t a, input logic [PTR_W:0] off);
    logic [PTR_W+1:0] s;
    s = {2'b00, a} + {1'b0, off};
    if (s >= (PTR_W+2)'(FRAME_BYTES)) begin
      s = s - (PTR_W+2)'(FRAME_BYTES);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/scfd_ram.sv -----
`timescale 1ns / 1ps

module scfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sum_checked_frame_deframer.sv -----
`timescale 1ns / 1ps
// A byte that leaves the window short of a frame is taken in ST_IDLE; one that fills it goes to ST_EVAL.
// Byte into a full window: oldest byte dropped, then ST_SLIDE reads the next marker from the window RAM.
// Good frame: ST_EMIT_RD and ST_EMIT_LD per payload byte, one window RAM read per byte, all before
// the next byte is taken; an error result adds no state while the output register is free.
// Cycles with out_tready low on a held result add stalls.
// Synchronous active-low reset clears the window fill, counters, marker registers and output valid.
module sum_checked_frame_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [scfd_pkg::OUT_DATA_W-1:0] out_tdata, // payload_byte, good_frames, bad_frames
  output logic                           out_tuser,  // kind
  output logic                           out_tlast   // last
);

  import scfd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_EVAL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  state_t            state_r;
  logic [7:0]        sync_r;
  logic [7:0]        len_r;
  ptr_t              head_r;
  logic [FILL_W-1:0] fill_r;
  logic [15:0]       sum_r;
  logic [7:0]        w0_r;
  logic [7:0]        w1_r;
  logic [7:0]        nb1_r;
  logic [7:0]        nb2_r;
  logic [15:0]       good_r;
  logic [15:0]       bad_r;
  logic [CNT_W-1:0]  k_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_kind_r;
  logic              out_last_r;
  logic [15:0]       out_good_r;
  logic [15:0]       out_bad_r;

  logic        ram_we;
  ptr_t        ram_waddr;
  ptr_t        ram_raddr;
  logic [7:0]  ram_rdata;
  logic        in_fire;
  logic        full;
  logic        out_free;
  logic [15:0] chk;
  logic [15:0] recv;
  logic        markers_ok;
  logic        out_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign full       = (fill_r == FILL_W'(FRAME_BYTES));
  assign out_free   = !out_valid_r || out_tready;
  assign chk        = sum_r - {8'h00, nb1_r} - {8'h00, nb2_r};
  assign recv       = {nb1_r, nb2_r};
  assign markers_ok = (w0_r == len_r) && (w1_r == sync_r);
  assign out_load   = (state_r == ST_EMIT_LD) ||
                      ((state_r == ST_EVAL) && markers_ok && (chk != recv) && out_free);

  always_comb begin
    ram_we    = in_fire;
    ram_waddr = full ? head_r : ptr_add(head_r, (PTR_W+1)'(fill_r));
    if (state_r == ST_IDLE) begin
      ram_raddr = ptr_add(head_r, (PTR_W+1)'(2));
    end else begin
      ram_raddr = ptr_add(head_r, (PTR_W+1)'(k_r) + (PTR_W+1)'(2));
    end
  end

  scfd_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_tdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sync_r      <= '0;
      len_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SYNC_BYTE:   sync_r <= cfg_wdata;
          CFG_LENGTH_CODE: len_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            nb1_r <= in_tdata;
            nb2_r <= nb1_r;
            if (full) begin
              // drop oldest, shift markers
              sum_r   <= sum_r - {8'h00, w0_r} + {8'h00, in_tdata};
              w0_r    <= w1_r;
              head_r  <= ptr_add(head_r, (PTR_W+1)'(1));
              state_r <= ST_SLIDE;
            end else begin
              sum_r  <= sum_r + {8'h00, in_tdata};
              fill_r <= fill_r + FILL_W'(1);
              if (fill_r == FILL_W'(0)) begin
                w0_r <= in_tdata;
              end
              if (fill_r == FILL_W'(1)) begin
                w1_r <= in_tdata;
              end
              if (fill_r == FILL_W'(FRAME_BYTES - 1)) begin
                state_r <= ST_EVAL;
              end
            end
          end
        end
        ST_SLIDE: begin
          w1_r    <= ram_rdata;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!markers_ok) begin
            state_r <= ST_IDLE;
          end else if (chk == recv) begin
            good_r  <= good_r + 16'd1;
            k_r     <= '0;
            state_r <= ST_EMIT_RD;
          end else if (out_free) begin
            bad_r       <= bad_r + 16'd1;
            out_kind_r  <= KIND_ERROR;
            out_byte_r  <= 8'h00;
            out_last_r  <= 1'b1;
            out_good_r  <= good_r;
            out_bad_r   <= bad_r + 16'd1;
            state_r     <= ST_IDLE;
          end
        end
        ST_EMIT_RD: begin
          if (out_free) begin
            state_r <= ST_EMIT_LD;
          end
        end
        ST_EMIT_LD: begin
          out_kind_r  <= KIND_PAYLOAD;
          out_byte_r  <= ram_rdata;
          out_good_r  <= good_r;
          out_bad_r   <= bad_r;
          if (k_r == CNT_W'(PAYLOAD_BYTES - 1)) begin
            out_last_r <= 1'b1;
            fill_r     <= '0;
            sum_r      <= '0;
            head_r     <= '0;
            state_r    <= ST_IDLE;
          end else begin
            out_last_r <= 1'b0;
            k_r        <= k_r + CNT_W'(1);
            state_r    <= ST_EMIT_RD;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bad_r, out_good_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import scfd_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int IDLE_PCT      = 18;
  localparam int SETTLE_CYC    = 8;
  localparam int ERR_RUN_BYTES = 45;
  localparam int PHASE_BYTES   = 16;

  typedef enum {PAT_RANDOM, PAT_ZERO, PAT_ONES} pattern_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic        last;
    logic [15:0] good;
    logic [15:0] bad;
  } frame_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic                  cfg_addr   = CFG_SYNC_BYTE;
  logic [7:0]            cfg_wdata  = 8'h00;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = 8'h00;  // rx_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;           // payload_byte, good_frames, bad_frames
  logic                  out_tuser;           // kind
  logic                  out_tlast;           // last

  logic [7:0]    sync_code;
  logic [7:0]    len_code;
  logic [7:0]    rx_window [FRAME_BYTES];
  int unsigned   window_fill;
  logic [15:0]   good_total;
  logic [15:0]   bad_total;
  frame_result_t pending_results [$];

  bit          idling_on       = 1'b1;
  int unsigned mismatches      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles    = 0;

  sum_checked_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_deframer_state();
    sync_code   = 8'h00;
    len_code    = 8'h00;
    window_fill = 0;
    good_total  = 16'h0000;
    bad_total   = 16'h0000;
    for (int i = 0; i < FRAME_BYTES; i++) rx_window[i] = 8'h00;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0]   sum;
    logic [15:0]   recv;
    frame_result_t r;
    if (window_fill >= FRAME_BYTES) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) rx_window[i] = rx_window[i+1];
      window_fill = FRAME_BYTES - 1;
    end
    rx_window[window_fill] = b;
    window_fill++;
    if (window_fill < FRAME_BYTES) return;
    if (rx_window[0] != len_code || rx_window[1] != sync_code) return;
    sum = {8'h00, sync_code} + {8'h00, len_code};
    for (int i = 0; i < PAYLOAD_BYTES; i++) sum = sum + {8'h00, rx_window[2+i]};
    recv = {rx_window[FRAME_BYTES-1], rx_window[FRAME_BYTES-2]};
    if (sum == recv) begin
      good_total = good_total + 16'd1;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        r.kind    = KIND_PAYLOAD;
        r.payload = rx_window[2+i];
        r.last    = (i == PAYLOAD_BYTES - 1);
        r.good    = good_total;
        r.bad     = bad_total;
        pending_results.push_back(r);
      end
      window_fill = 0;
    end else begin
      bad_total = bad_total + 16'd1;
      r.kind    = KIND_ERROR;
      r.payload = 8'h00;
      r.last    = 1'b1;
      r.good    = good_total;
      r.bad     = bad_total;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual kind=%0d byte=%02h last=%0d",
                 $time, out_tuser, out_tdata[7:0], out_tlast);
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 16'(want.kind), 16'(out_tuser));
        compare_field("payload_byte", 16'(want.payload), 16'(out_tdata[7:0]));
        compare_field("last", 16'(want.last), 16'(out_tlast));
        compare_field("good_frames", want.good, out_tdata[23:8]);
        compare_field("bad_frames", want.bad, out_tdata[39:24]);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !idling_on || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (idling_on && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input pattern_t pat, input bit bad_sum);
    logic [7:0]  body [PAYLOAD_BYTES];
    logic [15:0] sum;
    sum = {8'h00, sync_code} + {8'h00, len_code};
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case (pat)
        PAT_ZERO: body[i] = 8'h00;
        PAT_ONES: body[i] = 8'hFF;
        default:  body[i] = 8'($urandom);
      endcase
      sum = sum + {8'h00, body[i]};
    end
    if (bad_sum) sum = sum ^ 16'($urandom_range(65535, 1));
    send_byte(len_code);
    send_byte(sync_code);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(body[i]);
    send_byte(sum[7:0]);
    send_byte(sum[15:8]);
  endtask

  // hold off until every predicted result has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] sync_v, input logic [7:0] len_v);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SYNC_BYTE;
    cfg_wdata <= sync_v;
    @(posedge clk);
    sync_code = sync_v;
    cfg_addr  <= CFG_LENGTH_CODE;
    cfg_wdata <= len_v;
    @(posedge clk);
    len_code = len_v;
    cfg_we   <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_frame(PAT_ZERO, 1'b0);
    drain();
  endtask

  task automatic test_marker_extremes();
    set_markers(8'hFF, 8'h00);
    send_frame(PAT_ONES, 1'b0);
    drain();
    set_markers(8'h00, 8'hFF);
    send_frame(PAT_RANDOM, 1'b1);
    repeat (3) send_byte(8'h5A);
    drain();
  endtask

  task automatic test_error_run();
    set_markers(8'hFF, 8'hFF);
    idling_on = 1'b0;
    repeat (ERR_RUN_BYTES) send_byte(8'hFF);
    drain();
    idling_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0]  phase_sync [2];
    logic [7:0]  phase_len  [2];
    int unsigned start;
    int          pick;
    phase_sync[0] = 8'($urandom); phase_len[0] = 8'($urandom);
    phase_sync[1] = 8'($urandom); phase_len[1] = 8'($urandom);
    for (int p = 0; p < 2; p++) begin
      set_markers(phase_sync[p], phase_len[p]);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_frame(PAT_RANDOM, 1'b0);
        end else if (pick < 70) begin
          send_frame(PAT_RANDOM, 1'b1);
        end else if (pick < 85) begin
          repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
        end else begin
          send_byte(len_code);
          send_byte(sync_code);
          repeat ($urandom_range(20)) send_byte(8'($urandom));
        end
      end
      drain();
    end
  endtask

  initial begin
    clear_deframer_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_marker_extremes();
    test_error_run();
    test_random_traffic();
    $display("Covered reset-default markers, extreme markers, good and failing checksums,");
    $display("a run of back-to-back checksum errors and random framing: %0d bytes in, %0d %s",
             bytes_sent, results_checked, $sformatf("results (%0d/%0d frames)",
             good_total, bad_total));
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/scfd_pkg.sv
rtl/scfd_ram.sv
rtl/sum_checked_frame_deframer.sv
dv/testbench.sv
